// ===== rtl/i2cmts_pkg.sv =====
package i2cmts_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int STORE_AW     = $clog2(BUFFER_DEPTH);
	localparam int POS_W        = 5;
	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	localparam int APB_AW = 3;

	localparam logic REG_MSG_LEN   = 1'b0;
	localparam logic REG_SEND_STOP = 1'b1;

	localparam logic [1:0] MODE_WR    = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_EVENT = 2'd2;
	localparam logic [1:0] MODE_RD    = 2'd3;

	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_REPSTART   = 4'd1;
	localparam logic [3:0] ST_WADR_ACK   = 4'd2;
	localparam logic [3:0] ST_WADR_NACK  = 4'd3;
	localparam logic [3:0] ST_WDATA_ACK  = 4'd4;
	localparam logic [3:0] ST_WDATA_NACK = 4'd5;
	localparam logic [3:0] ST_ARBLOST    = 4'd6;
	localparam logic [3:0] ST_RADR_ACK   = 4'd7;
	localparam logic [3:0] ST_RADR_NACK  = 4'd8;
	localparam logic [3:0] ST_RDATA_ACK  = 4'd9;
	localparam logic [3:0] ST_RDATA_NACK = 4'd10;
	localparam logic [3:0] ST_BUSERR     = 4'd11;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_WADR_NACK  = 3'd1;
	localparam logic [2:0] ERR_WDATA_NACK = 3'd2;
	localparam logic [2:0] ERR_RADR_NACK  = 3'd3;
	localparam logic [2:0] ERR_BUS        = 3'd4;
	localparam logic [2:0] ERR_OTHER      = 3'd5;
	localparam logic [2:0] ERR_IDLE       = 3'd6;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] index;
		logic [7:0] data;
		logic [3:0] bus_status;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       continue_irq;
		logic       clear_flag;
		logic       send_ack;
		logic       send_start;
		logic       send_stop_now;
		logic [7:0] read_byte;
		logic       done_good;
		logic [2:0] last_error;
		logic       busy_res;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             good;
		logic [2:0]       err;
		logic             busy;
	} xfer_state_t;

	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

endpackage

// ===== rtl/i2cmts_step.sv =====
module i2cmts_step import i2cmts_pkg::*; (
	input  req_t             req,
	input  xfer_state_t      cur,
	input  logic [4:0]       msg_len,
	input  logic             stop_en,
	input  logic [7:0]       rd_data,
	output logic [POS_W-1:0] rd_addr,
	output xfer_state_t      nxt,
	output store_wr_t        wr,
	output rsp_t             rsp
);

	logic             is_start;
	logic [POS_W-1:0] pos_eff;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] ack_pos;

	assign is_start = (req.bus_status == ST_START) || (req.bus_status == ST_REPSTART);
	assign pos_eff  = is_start ? '0 : cur.pos;
	assign pos_inc  = (pos_eff == POS_MAX) ? pos_eff : pos_eff + 1'b1;
	assign ack_pos  = (req.bus_status == ST_RDATA_ACK) ? pos_inc : cur.pos;
	assign rd_addr  = (req.mode == MODE_RD) ? POS_W'(req.index) : pos_eff;

	always_comb begin
		nxt = cur;
		wr  = '0;
		rsp = '0;
		case (req.mode)
			MODE_WR: begin
				if (!cur.busy) begin
					wr.en   = 1'b1;
					wr.addr = POS_W'(req.index);
					wr.data = req.data;
				end
			end
			MODE_START: begin
				if (!cur.busy) begin
					nxt.good = 1'b0;
					nxt.err  = ERR_IDLE;
					nxt.busy = 1'b1;
					rsp.continue_irq = 1'b1;
					rsp.clear_flag   = 1'b1;
					rsp.send_start   = 1'b1;
				end
			end
			MODE_RD: begin
				rsp.read_byte = rd_data;
			end
			default: begin
				if (cur.busy) begin
					case (req.bus_status)
						ST_START, ST_REPSTART, ST_WADR_ACK, ST_WDATA_ACK: begin
							nxt.pos = pos_eff;
							if (pos_eff < msg_len) begin
								rsp.tx_byte      = rd_data;
								rsp.tx_valid     = 1'b1;
								rsp.continue_irq = 1'b1;
								rsp.clear_flag   = 1'b1;
								nxt.pos          = pos_inc;
							end else begin
								nxt.good = 1'b1;
								nxt.busy = 1'b0;
								rsp.clear_flag    = stop_en;
								rsp.send_stop_now = stop_en;
							end
						end
						ST_RADR_ACK, ST_RDATA_ACK: begin
							if (req.bus_status == ST_RDATA_ACK) begin
								wr.en   = 1'b1;
								wr.addr = cur.pos;
								wr.data = req.data;
								nxt.pos = pos_inc;
							end
							rsp.continue_irq = 1'b1;
							rsp.clear_flag   = 1'b1;
							rsp.send_ack     = (msg_len != '0) && (ack_pos < msg_len - 5'd1);
						end
						ST_RDATA_NACK: begin
							wr.en   = 1'b1;
							wr.addr = cur.pos;
							wr.data = req.data;
							nxt.good = 1'b1;
							nxt.busy = 1'b0;
							rsp.clear_flag    = 1'b1;
							rsp.send_stop_now = 1'b1;
						end
						ST_ARBLOST: begin
							rsp.continue_irq = 1'b1;
							rsp.clear_flag   = 1'b1;
							rsp.send_start   = 1'b1;
						end
						ST_WADR_NACK, ST_WDATA_NACK, ST_RADR_NACK: begin
							if (req.bus_status == ST_WADR_NACK)
								nxt.err = ERR_WADR_NACK;
							else if (req.bus_status == ST_WDATA_NACK)
								nxt.err = ERR_WDATA_NACK;
							else
								nxt.err = ERR_RADR_NACK;
							nxt.busy = 1'b0;
							rsp.clear_flag    = 1'b1;
							rsp.send_stop_now = 1'b1;
						end
						ST_BUSERR: begin
							nxt.err  = ERR_BUS;
							nxt.busy = 1'b0;
						end
						default: begin
							nxt.err  = ERR_OTHER;
							nxt.busy = 1'b0;
						end
					endcase
				end
			end
		endcase
		rsp.done_good  = nxt.good;
		rsp.last_error = nxt.err;
		rsp.busy_res   = nxt.busy;
	end

endmodule

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// I2C master transfer sequencer.
// Request channel (req_valid/req_stall/req): each word is a buffer write, a
// transfer start, a bus status event or a buffer read, chosen by req.mode.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one word per request,
// in order, carrying the bus action plus done/error/busy status after it.
// Config: APB registers message_length at 0x0 and send_stop at 0x4; write
// only while no request is in flight.
// Flow: an accepted request waits in the request register; its response is then
// loaded into the response register. Throughput: one request per cycle while the
// receiver does not stall; all work is one decode, one read of the 16 x 8 flop
// buffer and one position update between the request and response registers.
// Reset: busy, done flags and position cleared, last error = 6, message_length
// = 1, send_stop = 1; buffer contents are undefined until written.
// Receiver stall: the response register holds; the request register still
// takes a word while empty, then req_stall rises until the response moves.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic             req_vld_s1;
	req_t             req_s1;
	logic             rsp_vld_s2;
	rsp_t             rsp_s2;
	xfer_state_t      state_q;
	xfer_state_t      state_nx;
	logic [4:0]       msg_len_q;
	logic             send_stop_q;
	logic [7:0]       store_q [BUFFER_DEPTH];
	logic [POS_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	store_wr_t        wr;
	rsp_t             rsp_nx;
	logic             advance;
	logic             fire;
	logic             cfg_wr;

	assign advance   = !rsp_vld_s2 || !rsp_stall;
	assign fire      = req_vld_s1 && advance;
	assign req_stall = req_vld_s1 && !advance;
	assign rsp_valid = rsp_vld_s2;
	assign rsp       = rsp_s2;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_SEND_STOP) ? {31'b0, send_stop_q} : {27'b0, msg_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q   <= 5'd1;
			send_stop_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MSG_LEN:   msg_len_q   <= pwdata[4:0];
				REG_SEND_STOP: send_stop_q <= pwdata[0];
				default:       msg_len_q   <= msg_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
			rsp_vld_s2 <= 1'b0;
			state_q    <= '{pos: '0, good: 1'b0, err: ERR_IDLE, busy: 1'b0};
		end else begin
			if (!req_stall)
				req_vld_s1 <= req_valid;
			if (advance)
				rsp_vld_s2 <= req_vld_s1;
			if (fire)
				state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
		if (fire)
			rsp_s2 <= rsp_nx;
	end

	// message buffer: flops, one muxed read address
	assign rd_data = (int'(rd_addr) < BUFFER_DEPTH) ? store_q[STORE_AW'(rd_addr)] : 8'd0;

	always_ff @(posedge clk) begin
		if (fire && wr.en && (int'(wr.addr) < BUFFER_DEPTH))
			store_q[STORE_AW'(wr.addr)] <= wr.data;
	end

	i2cmts_step u_step (
		.req     (req_s1),
		.cur     (state_q),
		.msg_len (msg_len_q),
		.stop_en (send_stop_q),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.nxt     (state_nx),
		.wr      (wr),
		.rsp     (rsp_nx)
	);

	a_status_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_s2 |-> (rsp_s2.busy_res == state_q.busy && rsp_s2.done_good == state_q.good
			&& rsp_s2.last_error == state_q.err))
		else $error("response status out of step with transfer state");

	a_tx_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_s2 && rsp_s2.tx_valid |-> rsp_s2.continue_irq && rsp_s2.clear_flag
			&& !rsp_s2.send_stop_now)
		else $error("byte load without continue/clear or with stop");

	a_err_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.err != ERR_NONE)
		else $error("error code zero");

	a_ack_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_s2 && rsp_s2.send_ack |-> rsp_s2.busy_res && rsp_s2.continue_irq)
		else $error("ack requested outside a live read");

endmodule
